// ===== hw/rtl/ble_pkg.sv =====
package ble_pkg;

  localparam int CAPACITY = 16;
  // count holds 0..CAPACITY
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // wide enough for the count and the 5-bit position field
  localparam int POS_W    = (CNT_W > 5) ? CNT_W : 5;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_FIND       = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                     insert;
    logic                     pop_front;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ble_cell.sv =====
module ble_cell
  import ble_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [POS_W-1:0]         idx,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] entry_o,
  output logic                     match_o
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // Pick the new word: shift up past the insert point, take the word at it,
  // shift down on a front removal, else hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert) begin
      if (idx > ctrl.pos) begin
        entry_nxt = left_i;
      end else if (idx == ctrl.pos) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.pop_front) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Compare only occupied cells
  assign match_o = (idx < ctrl.count) && (entry_r == ctrl.value);
  assign entry_o = entry_r;

endmodule

// ===== hw/rtl/bounded_list_engine_core.sv =====
// The result of an input transfer is registered straight into the output register.
// Throughput: one command per cycle while in_stall is low; every command, shifts
// included, completes as the cell row moves each word one place at once.
// Input stalls only while a result waits in the output register and is stalled.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
module bounded_list_engine_core
  import ble_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_command,
  input  logic signed [31:0]       in_value,
  input  logic [4:0]               in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic signed [31:0]       out_value_out,
  output logic [3:0]               out_found_index,
  output logic [4:0]               out_length
);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               status_r, status_nxt;
  logic signed [DATA_W-1:0] vout_r, vout_nxt;
  logic [3:0]               fidx_r, fidx_nxt;
  logic [4:0]               len_r;

  logic                     accept;
  logic                     full, empty;
  logic [POS_W-1:0]         cnt_ext, pos_ext;
  logic                     match_any;
  logic [POS_W-1:0]         match_idx;
  logic signed [DATA_W-1:0] last_word;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]      match;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cnt_ext  = POS_W'(count_r);
  assign pos_ext  = POS_W'(in_position);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  // Row of cells, each handing its word to the neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ent[0];
    end else begin : g_left
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ent[i];
    end else begin : g_right
      assign right_w = ent[i+1];
    end
    ble_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .idx     (POS_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[i]),
      .match_o (match[i])
    );
  end

  // Find the first matching cell and the word at the back
  always_comb begin
    match_any = |match;
    match_idx = '0;
    last_word = ent[0];
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match[k]) begin
        match_idx = POS_W'(k);
      end
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (cnt_ext == POS_W'(k + 1)) begin
        last_word = ent[k];
      end
    end
  end

  // Decode the command into cell control, status, result fields and next count
  always_comb begin
    ctrl.insert    = 1'b0;
    ctrl.pop_front = 1'b0;
    ctrl.pos       = pos_ext;
    ctrl.count     = cnt_ext;
    ctrl.value     = in_value;
    status_nxt     = ST_OK;
    vout_nxt       = '0;
    fidx_nxt       = '0;
    count_nxt      = count_r;
    unique case (in_command)
      CMD_PUSH_BACK: begin
        ctrl.pos = cnt_ext;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          vout_nxt  = last_word;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        ctrl.pos = '0;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept;
          vout_nxt       = ent[0];
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else begin
          ctrl.insert = accept;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      CMD_FIND: begin
        if (match_any) begin
          vout_nxt = in_value;
          fidx_nxt = match_idx[3:0];
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result until its transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Capture result payload on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
      fidx_r   <= fidx_nxt;
      len_r    <= 5'(POS_W'(count_nxt));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = vout_r;
  assign out_found_index = fidx_r;
  assign out_length      = len_r;

endmodule
